// ===== sv/sccb_bus_master_unit_assert.svh =====
// assertion helpers shared by the sccb bus master files
`ifndef SCCB_BUS_MASTER_UNIT_ASSERT_SVH
`define SCCB_BUS_MASTER_UNIT_ASSERT_SVH

// same-cycle implication
`define SBM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sbm_pkg.sv =====
package sbm_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TICKS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_RETRIES = 2'd2;

	localparam logic [1:0] REQ_NONE   = 2'd0;
	localparam logic [1:0] REQ_WRITE  = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;
	localparam logic [1:0] REQ_VERIFY = 2'd3;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       verify_failed;
		logic       request_dropped;
	} sbm_res_t;

endpackage

// ===== sv/sbm_req_if.sv =====
interface sbm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] sub_address;
	logic [7:0] write_data;
	logic       sda_sense;

	modport source (output valid, output req_type, output sub_address,
		output write_data, output sda_sense, input ready);
	modport sink (input valid, input req_type, input sub_address,
		input write_data, input sda_sense, output ready);
endinterface

// ===== sv/sbm_res_if.sv =====
interface sbm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       verify_failed;
	logic       request_dropped;

	modport source (output valid, output scl_out, output sda_out, output busy_res,
		output done_res, output read_data, output verify_failed,
		output request_dropped, input ready);
	modport sink (input valid, input scl_out, input sda_out, input busy_res,
		input done_res, input read_data, input verify_failed,
		input request_dropped, output ready);
endinterface

// ===== sv/sbm_core.sv =====
`include "sccb_bus_master_unit_assert.svh"

module sbm_core
	import sbm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  acc,
	input  logic [1:0]            req_type,
	input  logic [7:0]            sub_address,
	input  logic [7:0]            write_data,
	input  logic                  sda_sense,
	output sbm_res_t              res
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_START_A, ST_START_B, ST_START_C, ST_START_D,
		ST_SETUP, ST_HIGH, ST_LOW, ST_STOP_A, ST_STOP_B, ST_STOP_C
	} step_t;

	typedef enum logic [2:0] {
		FLD_ID, FLD_X1, FLD_ADDR, FLD_X2, FLD_DATA, FLD_X3, FLD_RD, FLD_NA
	} field_t;

	typedef enum logic [1:0] {
		CYC_WRITE, CYC_ADDR, CYC_READ
	} cycle_t;

	logic [7:0]  dev_id_q;
	logic [15:0] qticks_q;
	logic [3:0]  retries_q;

	step_t       step_q, n_step, tgt;
	field_t      field_q, n_field, nf;
	cycle_t      cyc_q, n_cyc, bkind;
	logic [3:0]  wait_q, n_wait, wait_dec;
	logic [15:0] pre_q, n_pre;
	logic [3:0]  bit_q, n_bit, bit_dec;
	logic [7:0]  shift_q, n_shift;
	logic [3:0]  att_q, n_att;
	logic [7:0]  addr_q, n_addr;
	logic [7:0]  hdata_q, n_hdata;
	logic [7:0]  rlatch_q, n_rlatch;
	logic        clk_lvl_q, n_clk_lvl;
	logic        dat_lvl_q, n_dat_lvl;
	logic [1:0]  reqk_q, n_reqk;
	logic [16:0] cnt;
	logic        go, begin_c, nf_stop, done, fail, dropped;
	logic [3:0]  w;

	function automatic logic field_writes(input field_t f);
		return (f == FLD_ID) || (f == FLD_ADDR) || (f == FLD_DATA) || (f == FLD_NA);
	endfunction

	always_comb begin
		n_step   = step_q;
		n_field  = field_q;
		n_cyc    = cyc_q;
		n_wait   = wait_q;
		n_pre    = pre_q;
		n_bit    = bit_q;
		n_shift  = shift_q;
		n_att    = att_q;
		n_addr   = addr_q;
		n_hdata  = hdata_q;
		n_rlatch = rlatch_q;
		n_clk_lvl = clk_lvl_q;
		n_dat_lvl = dat_lvl_q;
		n_reqk   = reqk_q;
		go       = 1'b0;
		tgt      = ST_IDLE;
		begin_c  = 1'b0;
		bkind    = CYC_WRITE;
		nf       = FLD_ID;
		nf_stop  = 1'b0;
		done     = 1'b0;
		fail     = 1'b0;
		dropped  = 1'b0;
		w        = 4'd1;
		cnt      = {1'b0, pre_q} + 17'd1;
		wait_dec = (wait_q != 4'd0) ? wait_q - 4'd1 : wait_q;
		bit_dec  = (bit_q != 4'd0) ? bit_q - 4'd1 : bit_q;

		if (step_q != ST_IDLE) begin
			dropped = (req_type != REQ_NONE);
			if (cnt >= {1'b0, qticks_q}) begin
				n_pre  = '0;
				n_wait = wait_dec;
				if (wait_dec == 4'd0) begin
					case (step_q)
						ST_START_A: begin go = 1'b1; tgt = ST_START_B; end
						ST_START_B: begin go = 1'b1; tgt = ST_START_C; end
						ST_START_C: begin go = 1'b1; tgt = ST_START_D; end
						ST_START_D: begin go = 1'b1; tgt = ST_SETUP; end
						ST_SETUP:   begin go = 1'b1; tgt = ST_HIGH; end
						ST_HIGH:    begin go = 1'b1; tgt = ST_LOW; end
						ST_LOW: begin
							n_bit = bit_dec;
							if (bit_dec != 4'd0) begin
								go  = 1'b1;
								tgt = ST_SETUP;
							end else begin
								if (field_q == FLD_RD) n_rlatch = shift_q;
								case (field_q)
									FLD_ID:   nf = FLD_X1;
									FLD_X1:   nf = (cyc_q == CYC_READ) ? FLD_RD : FLD_ADDR;
									FLD_ADDR: nf = FLD_X2;
									FLD_X2: begin
										nf = FLD_DATA;
										nf_stop = (cyc_q != CYC_WRITE);
									end
									FLD_DATA: nf = FLD_X3;
									FLD_RD:   nf = FLD_NA;
									default:  nf_stop = 1'b1;
								endcase
								go = 1'b1;
								if (nf_stop) begin
									tgt = ST_STOP_A;
								end else begin
									tgt     = ST_SETUP;
									n_field = nf;
									n_bit   = 4'd1;
									case (nf)
										FLD_ADDR: begin n_shift = addr_q; n_bit = 4'd8; end
										FLD_DATA: begin n_shift = hdata_q; n_bit = 4'd8; end
										FLD_RD:   begin n_shift = '0; n_bit = 4'd8; end
										default: ;
									endcase
								end
							end
						end
						ST_STOP_A: begin go = 1'b1; tgt = ST_STOP_B; end
						ST_STOP_B: begin go = 1'b1; tgt = ST_STOP_C; end
						ST_STOP_C: begin
							if (cyc_q == CYC_WRITE) begin
								if (reqk_q == REQ_VERIFY) begin
									begin_c = 1'b1;
									bkind   = CYC_ADDR;
								end else begin
									done = 1'b1;
								end
							end else if (cyc_q == CYC_ADDR) begin
								begin_c = 1'b1;
								bkind   = CYC_READ;
							end else if (reqk_q != REQ_VERIFY) begin
								done = 1'b1;
							end else if (rlatch_q == hdata_q) begin
								done = 1'b1;
							end else if (att_q < retries_q) begin
								n_att   = att_q + 4'd1;
								begin_c = 1'b1;
								bkind   = CYC_WRITE;
							end else begin
								done = 1'b1;
								fail = 1'b1;
							end
						end
						default: n_step = ST_IDLE;
					endcase
				end
			end else begin
				n_pre = cnt[15:0];
			end
		end else if (req_type != REQ_NONE) begin
			n_reqk  = req_type;
			n_addr  = sub_address;
			n_att   = '0;
			begin_c = 1'b1;
			if (req_type == REQ_READ) begin
				bkind = CYC_ADDR;
			end else begin
				n_hdata = write_data;
				bkind   = CYC_WRITE;
			end
		end

		if (done) begin
			n_step = ST_IDLE;
			n_wait = '0;
			n_pre  = '0;
		end

		if (begin_c) begin
			n_cyc   = bkind;
			n_field = FLD_ID;
			n_bit   = 4'd8;
			n_shift = {dev_id_q[7:1], (bkind == CYC_READ)};
			go      = 1'b1;
			tgt     = ST_START_A;
		end

		if (go) begin
			n_step = tgt;
			case (tgt)
				ST_START_A: n_clk_lvl = 1'b1;
				ST_START_B: begin n_dat_lvl = 1'b1; w = 4'd4; end
				ST_START_C: n_dat_lvl = 1'b0;
				ST_START_D: n_clk_lvl = 1'b0;
				ST_SETUP: begin
					if (n_field == FLD_NA) n_dat_lvl = 1'b1;
					else if (field_writes(n_field)) n_dat_lvl = n_shift[7];
				end
				ST_HIGH: begin n_clk_lvl = 1'b1; w = 4'd2; end
				ST_LOW: begin
					n_clk_lvl = 1'b0;
					if (n_field == FLD_RD) n_shift = {n_shift[6:0], sda_sense};
					else if (field_writes(n_field)) n_shift = {n_shift[6:0], 1'b0};
				end
				ST_STOP_A: n_dat_lvl = 1'b0;
				ST_STOP_B: n_clk_lvl = 1'b1;
				ST_STOP_C: begin n_dat_lvl = 1'b1; w = 4'd8; end
				default: begin n_step = ST_IDLE; w = 4'd0; end
			endcase
			n_wait = w;
			n_pre  = '0;
		end

		res.scl_out         = n_clk_lvl;
		res.sda_out         = n_dat_lvl;
		res.busy_res        = (n_step != ST_IDLE);
		res.done_res        = done;
		res.read_data       = n_rlatch;
		res.verify_failed   = done & fail;
		res.request_dropped = dropped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_id_q  <= '0;
			qticks_q  <= 16'd1;
			retries_q <= 4'd5;
			step_q    <= ST_IDLE;
			field_q   <= FLD_ID;
			cyc_q     <= CYC_WRITE;
			wait_q    <= '0;
			pre_q     <= '0;
			bit_q     <= '0;
			shift_q   <= '0;
			att_q     <= '0;
			addr_q    <= '0;
			hdata_q   <= '0;
			rlatch_q  <= '0;
			clk_lvl_q <= 1'b1;
			dat_lvl_q <= 1'b1;
			reqk_q    <= REQ_NONE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEVICE_ID:      dev_id_q  <= cfg_data[7:0];
					CFG_QUARTER_TICKS:  qticks_q  <= cfg_data;
					CFG_VERIFY_RETRIES: retries_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (acc) begin
				step_q    <= n_step;
				field_q   <= n_field;
				cyc_q     <= n_cyc;
				wait_q    <= n_wait;
				pre_q     <= n_pre;
				bit_q     <= n_bit;
				shift_q   <= n_shift;
				att_q     <= n_att;
				addr_q    <= n_addr;
				hdata_q   <= n_hdata;
				rlatch_q  <= n_rlatch;
				clk_lvl_q <= n_clk_lvl;
				dat_lvl_q <= n_dat_lvl;
				reqk_q    <= n_reqk;
			end
		end
	end

	`SBM_ASSERT_IMP(a_idle_lines_high, step_q == ST_IDLE, clk_lvl_q && dat_lvl_q, "lines not released while idle")
	`SBM_ASSERT_IMP(a_done_not_busy, acc && res.done_res, !res.busy_res, "done while still busy")
	`SBM_ASSERT_IMP(a_bit_range, 1'b1, bit_q <= 4'd8, "bit position out of range")
	`SBM_ASSERT_NXT(a_hold_no_request, !acc, $stable(step_q) && $stable(shift_q), "sequencer moved without a request")

endmodule

// ===== sv/sbm_skid.sv =====
`include "sccb_bus_master_unit_assert.svh"

module sbm_skid
	import sbm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sbm_res_t  in_data,
	sbm_res_if.source rsp
);

	logic     out_v_q, skid_v_q;
	sbm_res_t out_d_q, skid_d_q;
	logic     pop;

	assign in_ready = !skid_v_q;
	assign pop      = out_v_q && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_valid;
			end
		end else if (!out_v_q) begin
			out_v_q <= in_valid;
		end else if (in_valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) out_d_q <= skid_d_q;
			else if (in_valid) out_d_q <= in_data;
		end else if (!out_v_q) begin
			if (in_valid) out_d_q <= in_data;
		end else if (in_valid && !skid_v_q) begin
			skid_d_q <= in_data;
		end
	end

	assign rsp.valid           = out_v_q;
	assign rsp.scl_out         = out_d_q.scl_out;
	assign rsp.sda_out         = out_d_q.sda_out;
	assign rsp.busy_res        = out_d_q.busy_res;
	assign rsp.done_res        = out_d_q.done_res;
	assign rsp.read_data       = out_d_q.read_data;
	assign rsp.verify_failed   = out_d_q.verify_failed;
	assign rsp.request_dropped = out_d_q.request_dropped;

	`SBM_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q, "skid full with empty output")
	`SBM_ASSERT_NXT(a_skid_holds, skid_v_q && !pop, skid_v_q && $stable(skid_d_q), "stalled skid entry lost")
	`SBM_ASSERT_NXT(a_skid_drains, skid_v_q && pop, out_v_q && !skid_v_q, "skid entry not moved on")

endmodule

// ===== sv/sccb_bus_master_unit.sv =====
// sccb bus master: drives the camera control bus clock and data lines.
// req channel: one request per clock tick of the sequencer; req_type 0 is a
// plain tick, 1 write, 2 read, 3 verified write, with sub_address,
// write_data and the sensed data line level sda_sense.
// rsp channel: one result per request, in order, giving the line levels,
// busy, a done pulse, the last byte read, verify failure and whether a
// bus request was dropped because the sequencer was busy.
// cfg port: device_id, quarter_ticks and verify_retries, to be written while idle; the block does not enforce this.
// results: a result is registered into the output buffer when its request is taken.
// throughput: one request per cycle while req.ready is high; the sequencer
// state update is a single registered step, and a two-entry output buffer
// lets a request be taken while an earlier result still waits.
// when rsp stalls, one more request is taken into the buffer, then req.ready
// drops until the output drains.
// reset: bus lines released high, sequencer idle, registers at defaults.
module sccb_bus_master_unit
	import sbm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sbm_req_if.sink               req,
	sbm_res_if.source             rsp
);

	logic     acc;
	logic     buf_ready;
	sbm_res_t res;

	assign req.ready = buf_ready;
	assign acc       = req.valid && buf_ready;

	sbm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.acc         (acc),
		.req_type    (req.req_type),
		.sub_address (req.sub_address),
		.write_data  (req.write_data),
		.sda_sense   (req.sda_sense),
		.res         (res)
	);

	sbm_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (buf_ready),
		.in_data  (res),
		.rsp      (rsp)
	);

endmodule

// ===== dv/sccb_bus_master_unit_checker.sv =====
module sccb_bus_master_unit_checker
	import sbm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sbm_req_if                    req,
	sbm_res_if                    rsp,
	output int                    fail_count,
	output int                    pending,
	output logic                  bus_active
);

	typedef enum logic [3:0] {
		STP_IDLE, STP_START_A, STP_START_B, STP_START_C, STP_START_D,
		STP_SETUP, STP_HIGH, STP_LOW, STP_STOP_A, STP_STOP_B, STP_STOP_C
	} step_e;

	typedef enum logic [2:0] {
		FLD_ID, FLD_X1, FLD_ADDR, FLD_X2, FLD_DATA, FLD_X3, FLD_RD, FLD_NA
	} field_e;

	typedef enum logic [1:0] {CYC_WRITE, CYC_ADDR, CYC_READ} cycle_e;

	// register copies
	logic [7:0]  dev_id;
	logic [15:0] qticks;
	logic [3:0]  retries;

	// sequencer copy
	step_e       step;
	field_e      field;
	cycle_e      cyc;
	logic [1:0]  bus_kind;
	logic [3:0]  units_left;
	logic [15:0] prescale;
	logic [3:0]  bits_left;
	logic [7:0]  shreg;
	logic [3:0]  attempts;
	logic [7:0]  addr_hold;
	logic [7:0]  data_hold;
	logic [7:0]  rd_latch;
	logic        scl_lvl;
	logic        sda_lvl;
	logic        done_f;
	logic        fail_f;

	sbm_res_t expected_levels[$];
	sbm_res_t seen;
	sbm_res_t want;
	int mismatches;
	int results_seen;

	function automatic logic field_driven();
		return field == FLD_ID || field == FLD_ADDR || field == FLD_DATA || field == FLD_NA;
	endfunction

	function automatic void enter_step(step_e s, logic sda);
		int w;
		w = 1;
		step = s;
		case (s)
			STP_START_A: scl_lvl = 1'b1;
			STP_START_B: begin
				sda_lvl = 1'b1;
				w = 4;
			end
			STP_START_C: sda_lvl = 1'b0;
			STP_START_D: scl_lvl = 1'b0;
			STP_SETUP: begin
				if (field == FLD_NA)
					sda_lvl = 1'b1;
				else if (field_driven())
					sda_lvl = shreg[7];
			end
			STP_HIGH: begin
				scl_lvl = 1'b1;
				w = 2;
			end
			STP_LOW: begin
				scl_lvl = 1'b0;
				if (field == FLD_RD)
					shreg = {shreg[6:0], sda};
				else if (field_driven())
					shreg = {shreg[6:0], 1'b0};
			end
			STP_STOP_A: sda_lvl = 1'b0;
			STP_STOP_B: scl_lvl = 1'b1;
			STP_STOP_C: begin
				sda_lvl = 1'b1;
				w = 8;
			end
			default: begin
				step = STP_IDLE;
				w = 0;
			end
		endcase
		units_left = 4'(w);
		prescale = '0;
	endfunction

	function automatic void begin_cycle(cycle_e k);
		cyc = k;
		field = FLD_ID;
		bits_left = 4'd8;
		shreg = {dev_id[7:1], k == CYC_READ};
		enter_step(STP_START_A, 1'b0);
	endfunction

	function automatic void finish_request(logic failed);
		step = STP_IDLE;
		units_left = '0;
		prescale = '0;
		done_f = 1'b1;
		fail_f = failed;
	endfunction

	function automatic void next_field();
		field_e nf;
		logic to_stop;
		nf = field;
		to_stop = 1'b0;
		if (field == FLD_RD)
			rd_latch = shreg;
		case (field)
			FLD_ID: nf = FLD_X1;
			FLD_X1: nf = (cyc == CYC_READ) ? FLD_RD : FLD_ADDR;
			FLD_ADDR: nf = FLD_X2;
			FLD_X2: begin
				if (cyc == CYC_WRITE)
					nf = FLD_DATA;
				else
					to_stop = 1'b1;
			end
			FLD_DATA: nf = FLD_X3;
			FLD_RD: nf = FLD_NA;
			default: to_stop = 1'b1;
		endcase
		if (to_stop) begin
			enter_step(STP_STOP_A, 1'b0);
		end else begin
			field = nf;
			bits_left = 4'd1;
			if (nf == FLD_ADDR) begin
				shreg = addr_hold;
				bits_left = 4'd8;
			end else if (nf == FLD_DATA) begin
				shreg = data_hold;
				bits_left = 4'd8;
			end else if (nf == FLD_RD) begin
				shreg = '0;
				bits_left = 4'd8;
			end
			enter_step(STP_SETUP, 1'b0);
		end
	endfunction

	function automatic void end_cycle();
		if (cyc == CYC_WRITE) begin
			if (bus_kind == REQ_VERIFY)
				begin_cycle(CYC_ADDR);
			else
				finish_request(1'b0);
		end else if (cyc == CYC_ADDR) begin
			begin_cycle(CYC_READ);
		end else if (bus_kind != REQ_VERIFY) begin
			finish_request(1'b0);
		end else if (rd_latch == data_hold) begin
			finish_request(1'b0);
		end else if (attempts < retries) begin
			attempts = attempts + 4'd1;
			begin_cycle(CYC_WRITE);
		end else begin
			finish_request(1'b1);
		end
	endfunction

	function automatic void advance(logic sda);
		case (step)
			STP_START_A: enter_step(STP_START_B, sda);
			STP_START_B: enter_step(STP_START_C, sda);
			STP_START_C: enter_step(STP_START_D, sda);
			STP_START_D: enter_step(STP_SETUP, sda);
			STP_SETUP: enter_step(STP_HIGH, sda);
			STP_HIGH: enter_step(STP_LOW, sda);
			STP_LOW: begin
				if (bits_left > 0)
					bits_left = bits_left - 4'd1;
				if (bits_left > 0)
					enter_step(STP_SETUP, sda);
				else
					next_field();
			end
			STP_STOP_A: enter_step(STP_STOP_B, sda);
			STP_STOP_B: enter_step(STP_STOP_C, sda);
			STP_STOP_C: end_cycle();
			default: step = STP_IDLE;
		endcase
	endfunction

	function automatic sbm_res_t predict_tick(logic [1:0] kind, logic [7:0] addr,
		logic [7:0] wdata, logic sda);
		logic [16:0] cnt;
		logic dropped;
		sbm_res_t r;
		done_f = 1'b0;
		fail_f = 1'b0;
		dropped = 1'b0;
		if (step != STP_IDLE) begin
			cnt = {1'b0, prescale} + 17'd1;
			if (kind != REQ_NONE)
				dropped = 1'b1;
			// a zero prescale setting acts as one
			if (cnt >= {1'b0, qticks}) begin
				prescale = '0;
				if (units_left > 0)
					units_left = units_left - 4'd1;
				if (units_left == 0)
					advance(sda);
			end else begin
				prescale = cnt[15:0];
			end
		end else if (kind != REQ_NONE) begin
			bus_kind = kind;
			addr_hold = addr;
			attempts = '0;
			if (kind == REQ_READ) begin
				begin_cycle(CYC_ADDR);
			end else begin
				data_hold = wdata;
				begin_cycle(CYC_WRITE);
			end
		end
		r.scl_out = scl_lvl;
		r.sda_out = sda_lvl;
		r.busy_res = (step != STP_IDLE);
		r.done_res = done_f;
		r.read_data = rd_latch;
		r.verify_failed = done_f && fail_f;
		r.request_dropped = dropped;
		return r;
	endfunction

	function automatic void reset_model();
		dev_id = 8'h00;
		qticks = 16'd1;
		retries = 4'd5;
		step = STP_IDLE;
		field = FLD_ID;
		cyc = CYC_WRITE;
		bus_kind = REQ_NONE;
		units_left = '0;
		prescale = '0;
		bits_left = '0;
		shreg = '0;
		attempts = '0;
		addr_hold = '0;
		data_hold = '0;
		rd_latch = '0;
		scl_lvl = 1'b1;
		sda_lvl = 1'b1;
		done_f = 1'b0;
		fail_f = 1'b0;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at result %0d: %s", results_seen, msg);
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_val));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			expected_levels.delete();
			mismatches = 0;
			results_seen = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen.scl_out = rsp.scl_out;
				seen.sda_out = rsp.sda_out;
				seen.busy_res = rsp.busy_res;
				seen.done_res = rsp.done_res;
				seen.read_data = rsp.read_data;
				seen.verify_failed = rsp.verify_failed;
				seen.request_dropped = rsp.request_dropped;
				if (expected_levels.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = expected_levels.pop_front();
					check_field("scl_out", 8'(seen.scl_out), 8'(want.scl_out));
					check_field("sda_out", 8'(seen.sda_out), 8'(want.sda_out));
					check_field("busy_res", 8'(seen.busy_res), 8'(want.busy_res));
					check_field("done_res", 8'(seen.done_res), 8'(want.done_res));
					check_field("read_data", seen.read_data, want.read_data);
					check_field("verify_failed", 8'(seen.verify_failed),
						8'(want.verify_failed));
					check_field("request_dropped", 8'(seen.request_dropped),
						8'(want.request_dropped));
				end
				results_seen++;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEVICE_ID: dev_id = cfg_data[7:0];
					CFG_QUARTER_TICKS: qticks = cfg_data[15:0];
					CFG_VERIFY_RETRIES: retries = cfg_data[3:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				expected_levels.push_back(predict_tick(req.req_type, req.sub_address,
					req.write_data, req.sda_sense));
		end
		pending <= expected_levels.size();
		bus_active <= (step != STP_IDLE);
		fail_count <= mismatches;
	end

endmodule

// ===== dv/sccb_bus_master_unit_test.sv =====
module sccb_bus_master_unit_test;
	import sbm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2000000;

	typedef enum logic [1:0] {SENSE_RANDOM, SENSE_LOW, SENSE_HIGH} sense_e;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatch_count;
	int pending_count;
	logic bus_active;

	int send_idle;
	int recv_idle;
	int requests_sent;
	int unsigned cycle_count;
	sense_e sense_now;

	sbm_req_if req_ch();
	sbm_res_if rsp_ch();

	sccb_bus_master_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	sccb_bus_master_unit_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch),
		.fail_count(mismatch_count),
		.pending(pending_count),
		.bus_active(bus_active)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idling pattern follows the number of requests sent so far
	always @(negedge clk) begin
		if (requests_sent < 200) begin
			send_idle <= 20;
			recv_idle <= 86;
		end else if (requests_sent < 400) begin
			send_idle <= 86;
			recv_idle <= 20;
		end else begin
			send_idle <= 0;
			recv_idle <= 0;
		end
	end

	initial rsp_ch.ready = 1'b0;
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic sense_bit();
		case (sense_now)
			SENSE_LOW: return 1'b0;
			SENSE_HIGH: return 1'b1;
			default: return 1'($urandom_range(1));
		endcase
	endfunction

	// one request per call; valid stays high for a back-to-back request
	task automatic send_request(logic [1:0] kind, logic [7:0] addr, logic [7:0] wdata,
		logic sda);
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.sub_address <= addr;
		req_ch.write_data <= wdata;
		req_ch.sda_sense <= sda;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic send_tick(int noise);
		if ($urandom_range(99) < noise)
			send_request(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom), sense_bit());
		else
			send_request(REQ_NONE, 8'($urandom), 8'($urandom), sense_bit());
	endtask

	// one bus transfer, ticking until the sequencer is back to idle
	task automatic transfer(logic [1:0] kind, logic [7:0] addr, logic [7:0] wdata,
		sense_e mode, int noise);
		sense_now = mode;
		send_request(kind, addr, wdata, sense_bit());
		while (bus_active)
			send_tick(noise);
		sense_now = SENSE_RANDOM;
	endtask

	task automatic settle();
		while (bus_active)
			send_tick(0);
		req_ch.valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(logic [7:0] dev, logic [15:0] qt, logic [3:0] ret);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DEVICE_ID;
		cfg_data <= {8'h00, dev};
		@(negedge clk);
		cfg_index <= CFG_QUARTER_TICKS;
		cfg_data <= qt;
		@(negedge clk);
		cfg_index <= CFG_VERIFY_RETRIES;
		cfg_data <= {12'h000, ret};
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DEVICE_ID;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_NONE;
		req_ch.sub_address = '0;
		req_ch.write_data = '0;
		req_ch.sda_sense = 1'b1;
		sense_now = SENSE_RANDOM;
		requests_sent = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero prescale, no extra attempts
		set_config(8'hFF, 16'd0, 4'd0);
		repeat (3) send_tick(0);
		// requests on every busy tick, the done tick included
		transfer(REQ_WRITE, 8'hFF, 8'h00, SENSE_RANDOM, 100);
		transfer(REQ_READ, 8'hA5, 8'h00, SENSE_HIGH, 10);
		// read-back never matches the written byte
		transfer(REQ_VERIFY, 8'hC3, 8'h00, SENSE_HIGH, 0);

		// slowest prescale: only the opening of one write is seen
		settle();
		set_config(8'($urandom), 16'hFFFF, 4'($urandom));
		sense_now = SENSE_RANDOM;
		send_request(REQ_WRITE, 8'($urandom), 8'($urandom), sense_bit());
		repeat (20)
			send_tick(20);

		req_ch.valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sccb_bus_master_unit.f =====
+incdir+sv
sv/sbm_pkg.sv
sv/sbm_req_if.sv
sv/sbm_res_if.sv
sv/sbm_core.sv
sv/sbm_skid.sv
sv/sccb_bus_master_unit.sv
dv/sccb_bus_master_unit_checker.sv
dv/sccb_bus_master_unit_test.sv
